// ===== rtl/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int CFG_W          = 10;
	localparam int CFG_IDX_W      = 1;
	localparam int PIX_W          = 12;

	localparam logic [CFG_W-1:0] CENTER_X_RESET = 10'd320;
	localparam logic [CFG_W-1:0] CENTER_Y_RESET = 10'd240;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 1'b0,
		REG_CENTER_Y = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_STEP  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		Q_PP = 2'd0,
		Q_MP = 2'd1,
		Q_PM = 2'd2,
		Q_MM = 2'd3
	} quad_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ST1,
		ST_ST2,
		ST_ST3,
		ST_R1_0,
		ST_R1_1,
		ST_R1_2,
		ST_R1_3,
		ST_RC0,
		ST_RC1,
		ST_RC2,
		ST_RC3,
		ST_RC4,
		ST_RC5,
		ST_RC6,
		ST_R2_0,
		ST_R2_1,
		ST_R2_2,
		ST_EMIT,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/mer_mul.sv =====
// ----------------------------------------------------------------------------
// mer_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mer_mul
	import mer_pkg::*;
#(
	parameter int A_W = 31,
	parameter int B_W = 12
) (
	input  logic                 clk,
	input  logic [A_W-1:0]       op_a,
	input  logic [B_W-1:0]       op_b,
	output logic [A_W+B_W-1:0]   prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

endmodule

// ===== rtl/midpoint_ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Two-region midpoint ellipse rasterizer with four-way mirrored output.
// ----------------------------------------------------------------------------
// A start item (action 0) loads the radii and gives the top point mirrored
// into four quadrants around the programmed centre; each step item (action 1)
// advances one pixel and gives four pixels in quadrant order, last_of_run on
// the fourth. A step after the ellipse is complete gives one done result.
// Every product goes through one shared multiplier with a registered output,
// so an item is worked through a sequence of multiply and add states and
// the input stalls meanwhile: a start item runs ST_ST1 to ST_ST3, a step
// runs ST_R1_0 to ST_R1_3 or ST_R2_0 to ST_R2_2, the step that crosses into
// region two runs ST_R1_0 to ST_R1_2, ST_RC0 to ST_RC6 and then region two,
// and every result waits in ST_EMIT or ST_DONE while out_stall is held.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer
	import mer_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic [COORD_BITS-1:0]        radius_a,
	input  logic [COORD_BITS-1:0]        radius_b,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [PIX_W-1:0]      pixel_x,
	output logic signed [PIX_W-1:0]      pixel_y,
	output logic [1:0]                   quadrant,
	output logic                         last_of_run,
	output logic                         done_res
);

	localparam int CB    = COORD_BITS;
	localparam int SQ_W  = 2 * CB;
	localparam int MA_W  = 3 * CB + 1;
	localparam int MB_W  = CB + 2;
	localparam int MP_W  = MA_W + MB_W;
	localparam int CMP_W = 3 * CB + 3;
	localparam int DEC_W = (4 * CB + 4 > 64) ? 64 : 4 * CB + 4;

	state_t            state_q, state_nxt;
	quad_t             quad_q;
	logic              finished_q;
	logic              region2_q;
	logic              out_valid_q;
	logic [CFG_W-1:0]  center_x_q, center_y_q;

	logic [CB-1:0]     rad_b_q;
	logic [SQ_W-1:0]   sq_a_q, sq_b_q;
	logic [CB-1:0]     cur_x_q, cur_y_q;
	logic [DEC_W-1:0]  decision_q;
	logic [DEC_W-1:0]  tmp_q;

	logic [PIX_W-1:0]  pixel_x_q, pixel_y_q;
	quad_t             quadrant_q;
	logic              last_q, done_q;

	logic [MA_W-1:0]   mul_a;
	logic [MB_W-1:0]   mul_b;
	logic [MP_W-1:0]   prod_s1;

	logic              accept;
	logic              out_free;
	logic              emit_load, done_load;
	logic              dec_neg;
	logic              r1_go;
	logic [CB-1:0]     ty_abs;
	logic [DEC_W-1:0]  d_prod, d_sqa, d_sqb, ya4;
	logic [CMP_W-1:0]  lhs, rhs;
	logic [PIX_W-1:0]  cx12, cy12, dx12, dy12;

	mer_mul #(
		.A_W(MA_W),
		.B_W(MB_W)
	) u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_s1(prod_s1)
	);

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign dec_neg  = decision_q[DEC_W-1];
	assign ty_abs   = (cur_y_q == '0) ? CB'(1) : cur_y_q - CB'(1);

	assign d_prod = DEC_W'(prod_s1);
	assign d_sqa  = DEC_W'(sq_a_q);
	assign d_sqb  = DEC_W'(sq_b_q);
	assign ya4    = (d_sqa << 3) + (d_sqa << 2) - (tmp_q << 3);

	assign lhs   = CMP_W'(tmp_q) << 1;
	assign rhs   = (CMP_W'(prod_s1) << 1) + CMP_W'(sq_a_q);
	assign r1_go = lhs > rhs;

	assign cx12 = PIX_W'(center_x_q);
	assign cy12 = PIX_W'(center_y_q);
	assign dx12 = PIX_W'(cur_x_q);
	assign dy12 = PIX_W'(cur_y_q);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (action_t'(action) == ACT_START)
						state_nxt = ST_ST1;
					else if (finished_q)
						state_nxt = ST_DONE;
					else if (region2_q)
						state_nxt = ST_R2_0;
					else
						state_nxt = ST_R1_0;
				end
			end
			ST_ST1:  state_nxt = ST_ST2;
			ST_ST2:  state_nxt = ST_ST3;
			ST_ST3:  state_nxt = ST_EMIT;
			ST_R1_0: state_nxt = ST_R1_1;
			ST_R1_1: state_nxt = ST_R1_2;
			ST_R1_2: state_nxt = r1_go ? ST_R1_3 : ST_RC0;
			ST_R1_3: state_nxt = ST_EMIT;
			ST_RC0:  state_nxt = ST_RC1;
			ST_RC1:  state_nxt = ST_RC2;
			ST_RC2:  state_nxt = ST_RC3;
			ST_RC3:  state_nxt = ST_RC4;
			ST_RC4:  state_nxt = ST_RC5;
			ST_RC5:  state_nxt = ST_RC6;
			ST_RC6:  state_nxt = ST_R2_0;
			ST_R2_0: state_nxt = (cur_y_q == '0) ? ST_DONE : ST_R2_1;
			ST_R2_1: state_nxt = ST_R2_2;
			ST_R2_2: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (out_free && quad_q == Q_MM)
					state_nxt = ST_IDLE;
			end
			ST_DONE: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		emit_load = 1'b0;
		done_load = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				mul_a    = MA_W'(radius_a);
				mul_b    = MB_W'(radius_a);
			end
			ST_ST1: begin
				mul_a = MA_W'(rad_b_q);
				mul_b = MB_W'(rad_b_q);
			end
			ST_ST2: begin
				mul_a = MA_W'(sq_a_q);
				mul_b = MB_W'(rad_b_q);
			end
			ST_R1_0, ST_R2_0: begin
				mul_a = MA_W'(sq_a_q);
				mul_b = MB_W'(cur_y_q);
			end
			ST_R1_1: begin
				mul_a = MA_W'(sq_b_q);
				mul_b = MB_W'(cur_x_q) + MB_W'(1);
			end
			ST_R1_2: begin
				mul_a = MA_W'(sq_b_q);
				mul_b = MB_W'({cur_x_q, 1'b1}) + MB_W'(2);
			end
			ST_RC0: begin
				mul_a = MA_W'(sq_b_q);
				mul_b = MB_W'({cur_x_q, 1'b1});
			end
			ST_RC1: begin
				mul_a = MA_W'(prod_s1);
				mul_b = MB_W'({cur_x_q, 1'b1});
			end
			ST_RC2: begin
				mul_a = MA_W'(sq_a_q);
				mul_b = MB_W'(ty_abs);
			end
			ST_RC3: begin
				mul_a = MA_W'(prod_s1);
				mul_b = MB_W'(ty_abs);
			end
			ST_RC4: begin
				mul_a = MA_W'(sq_a_q);
				mul_b = MB_W'(rad_b_q);
			end
			ST_RC5: begin
				mul_a = MA_W'(prod_s1);
				mul_b = MB_W'(rad_b_q);
			end
			ST_R2_1: begin
				mul_a = MA_W'(sq_b_q);
				mul_b = MB_W'({cur_x_q, 1'b0}) + MB_W'(2);
			end
			ST_EMIT: emit_load = out_free;
			ST_DONE: done_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			quad_q      <= Q_PP;
			finished_q  <= 1'b1;
			region2_q   <= 1'b0;
			out_valid_q <= 1'b0;
			center_x_q  <= CENTER_X_RESET;
			center_y_q  <= CENTER_Y_RESET;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_CENTER_X: center_x_q <= cfg_data;
					REG_CENTER_Y: center_y_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && action_t'(action) == ACT_START) begin
				finished_q <= 1'b0;
				region2_q  <= 1'b0;
			end
			if (state_q == ST_RC6)
				region2_q <= 1'b1;
			if (state_q == ST_R2_0 && cur_y_q == '0)
				finished_q <= 1'b1;
			if (emit_load)
				quad_q <= quad_t'(quad_q + 2'd1);
			if (emit_load || done_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action_t'(action) == ACT_START)
			rad_b_q <= radius_b;
		case (state_q)
			ST_ST1: sq_a_q <= SQ_W'(prod_s1);
			ST_ST2: sq_b_q <= SQ_W'(prod_s1);
			ST_ST3: begin
				decision_q <= (d_sqb << 2) - (d_prod << 2) + d_sqa;
				cur_x_q    <= '0;
				cur_y_q    <= rad_b_q;
			end
			ST_R1_1, ST_R2_1, ST_RC2: tmp_q <= d_prod;
			ST_R1_3: begin
				if (dec_neg) begin
					decision_q <= decision_q + (d_prod << 2);
				end else begin
					decision_q <= decision_q + (d_prod << 2) - (tmp_q << 3) + (d_sqa << 3);
					cur_y_q    <= cur_y_q - CB'(1);
				end
				cur_x_q <= cur_x_q + CB'(1);
			end
			ST_RC4: tmp_q <= tmp_q + (d_prod << 2);
			ST_RC6: decision_q <= tmp_q - (d_prod << 2);
			ST_R2_2: begin
				if (dec_neg) begin
					decision_q <= decision_q + (d_prod << 2) + ya4;
					cur_x_q    <= cur_x_q + CB'(1);
				end else begin
					decision_q <= decision_q + ya4;
				end
				cur_y_q <= cur_y_q - CB'(1);
			end
			default: ;
		endcase
		if (emit_load) begin
			pixel_x_q  <= (quad_q == Q_MP || quad_q == Q_MM) ? cx12 - dx12 : cx12 + dx12;
			pixel_y_q  <= (quad_q == Q_PM || quad_q == Q_MM) ? cy12 - dy12 : cy12 + dy12;
			quadrant_q <= quad_q;
			last_q     <= (quad_q == Q_MM);
			done_q     <= 1'b0;
		end else if (done_load) begin
			pixel_x_q  <= '0;
			pixel_y_q  <= '0;
			quadrant_q <= Q_PP;
			last_q     <= 1'b1;
			done_q     <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = $signed(pixel_x_q);
	assign pixel_y     = $signed(pixel_y_q);
	assign quadrant    = quadrant_q;
	assign last_of_run = last_q;
	assign done_res    = done_q;

	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action_t'(action) == ACT_START |=> state_q == ST_ST1)
		else $error("start transfer did not enter the square sequence");

	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> last_of_run && quadrant == Q_PP)
		else $error("done result malformed");

	a_last_quad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> last_of_run == (quadrant == Q_MM))
		else $error("last_of_run not on the final quadrant");

	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load && quad_q == Q_MM |=> state_q == ST_IDLE && quad_q == Q_PP)
		else $error("emit run did not close after four pixels");

	a_r2_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_R2_1 |-> region2_q && !finished_q && cur_y_q != '0)
		else $error("region two step without a live ellipse");

endmodule
